// ----- design/ssp_pkg.sv -----
`timescale 1ns / 1ps

package ssp_pkg;

	// Fixed point format and largest frame dimension used
	localparam int FRACTION_BITS = 16;
	localparam int MAX_FRAME_DIM = 4096;

	// Configuration register width and frame dimension widths
	localparam int REG_W  = 13;
	localparam int DIM_W  = $clog2(MAX_FRAME_DIM + 1);
	localparam int HALF_W = DIM_W - 1;

	// Camera transform: |determinant| and |numerator| magnitudes
	localparam int DET_W  = 64;
	localparam int NUM_W  = 65;
	localparam int CAM_QB = 31;

	// Screen projection: screen quotient saturates at 2^SCR_QB
	localparam int SCR_QB = DIM_W + FRACTION_BITS + 1;
	localparam int SCR_W  = SCR_QB + 2;
	localparam int PROD_W = HALF_W + 34;
	localparam int SMAG_W = PROD_W - 1;
	localparam int SZN_W  = DIM_W + FRACTION_BITS;
	localparam int TY_W   = 31;

	// Register indexes
	localparam logic CFG_FRAME_WIDTH  = 1'b0;
	localparam logic CFG_FRAME_HEIGHT = 1'b1;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_BEHIND   = 2'd1,
		ST_SINGULAR = 2'd2
	} status_t;

	// Sideband that rides along the camera dividers
	typedef struct packed {
		logic singular;
		logic tx_neg;
		logic ty_neg;
	} cam_side_t;

	// Sideband that rides along the screen dividers
	typedef struct packed {
		logic signed [31:0] tx;
		logic signed [31:0] ty;
		status_t            status;
		logic               scr_neg;
	} scr_side_t;

endpackage

// ----- design/ssp_div.sv -----
`timescale 1ns / 1ps

// Pipelined restoring divider, one quotient bit per stage. The first stage
// flags a quotient of 2^QB or more; the remaining bits are valid otherwise.
module ssp_div
	import ssp_pkg::*;
#(
	parameter int NW = NUM_W + FRACTION_BITS,
	parameter int DW = DET_W,
	parameter int QB = CAM_QB
) (
	input  logic          clk,
	input  logic          en,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic [QB-1:0] quo,
	output logic          ovf
);

	localparam int CW = (NW > DW + QB) ? NW : DW + QB;
	localparam int EW = CW + 1;

	logic [NW-1:0] rem_s [QB+1];
	logic [DW-1:0] den_s [QB+1];
	logic [QB-1:0] quo_s [QB+1];
	logic          ovf_s [QB+1];

	// Capture operands and check for quotient overflow
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= num;
			den_s[0] <= den;
			quo_s[0] <= '0;
			ovf_s[0] <= EW'(num) >= (EW'(den) << QB);
		end
	end

	// Resolve one quotient bit per stage, most significant first
	for (genvar j = 0; j < QB; j++) begin : g_step
		localparam int K = QB - 1 - j;
		logic [EW-1:0] shifted;
		logic          take;

		assign shifted = EW'(den_s[j]) << K;
		assign take    = EW'(rem_s[j]) >= shifted;

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j+1] <= take ? NW'(EW'(rem_s[j]) - shifted) : rem_s[j];
				den_s[j+1] <= den_s[j];
				quo_s[j+1] <= quo_s[j] | (QB'(take) << K);
				ovf_s[j+1] <= ovf_s[j];
			end
		end
	end

	assign quo = quo_s[QB];
	assign ovf = ovf_s[QB];

endmodule

// ----- design/sprite_screen_projection.sv -----
`timescale 1ns / 1ps

// Sprite screen projection: takes one sprite per cycle when not stalled and
// returns its camera-space position, screen column, size and clipped draw
// bounds from 11 arithmetic stages plus a 32-stage and a 31-stage pipelined
// divider, each resolving one quotient bit per stage.
// The pipeline advances as a whole: while a result waits with out_stall high
// every stage holds and in_stall is raised; otherwise one transaction enters
// and one leaves each cycle. The user must write frame width and height
// through the wr_en port only while the pipeline is empty; the block does not
// enforce this. Values above the maximum frame dimension are clamped to it.
module sprite_screen_projection
	import ssp_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_en,
	input  logic               wr_index,
	input  logic [REG_W-1:0]   wr_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] player_pos_x,
	input  logic signed [31:0] player_pos_y,
	input  logic signed [31:0] view_dir_x,
	input  logic signed [31:0] view_dir_y,
	input  logic signed [31:0] cam_plane_x,
	input  logic signed [31:0] cam_plane_y,
	input  logic signed [31:0] sprite_pos_x,
	input  logic signed [31:0] sprite_pos_y,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] cam_space_x,
	output logic signed [31:0] cam_space_depth,
	output logic signed [15:0] screen_column,
	output logic [15:0]        sprite_extent,
	output logic [14:0]        first_column,
	output logic signed [15:0] end_column,
	output logic [11:0]        first_row,
	output logic [11:0]        end_row,
	output logic [1:0]         status
);

	localparam int D1    = CAM_QB + 1;
	localparam int D2    = SCR_QB + 1;
	localparam int DEPTH = 11 + D1 + D2;

	logic             en;
	logic [DEPTH-1:0] vld_q;
	logic [REG_W-1:0] frame_width_q;
	logic [REG_W-1:0] frame_height_q;
	logic [DIM_W-1:0] w_eff;
	logic [DIM_W-1:0] h_eff;
	logic [HALF_W-1:0] half_w;
	logic [HALF_W-1:0] half_h;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= REG_W'(640);
			frame_height_q <= REG_W'(480);
		end else if (wr_en) begin
			unique case (wr_index)
				CFG_FRAME_WIDTH:  frame_width_q  <= wr_data;
				CFG_FRAME_HEIGHT: frame_height_q <= wr_data;
				default: ;
			endcase
		end
	end

	// Limit frame dimensions to the supported maximum
	always_comb begin
		w_eff = (int'(frame_width_q) > MAX_FRAME_DIM) ? DIM_W'(MAX_FRAME_DIM)
			: DIM_W'(frame_width_q);
		h_eff = (int'(frame_height_q) > MAX_FRAME_DIM) ? DIM_W'(MAX_FRAME_DIM)
			: DIM_W'(frame_height_q);
		half_w = HALF_W'(w_eff >> 1);
		half_h = HALF_W'(h_eff >> 1);
	end

	// Global advance: hold everything while the result is stalled
	assign en        = !(vld_q[DEPTH-1] && out_stall);
	assign in_stall  = !en;
	assign out_valid = vld_q[DEPTH-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[DEPTH-2:0], in_valid};
		end
	end

	// Stage 1: relative sprite position
	logic signed [32:0] dx_s1, dy_s1;
	logic signed [31:0] dirx_s1, diry_s1, plx_s1, ply_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1   <= 33'(sprite_pos_x) - 33'(player_pos_x);
			dy_s1   <= 33'(sprite_pos_y) - 33'(player_pos_y);
			dirx_s1 <= view_dir_x;
			diry_s1 <= view_dir_y;
			plx_s1  <= cam_plane_x;
			ply_s1  <= cam_plane_y;
		end
	end

	// Stage 2: products of the inverse camera matrix
	logic signed [63:0] pda_s2, pdb_s2;
	logic signed [64:0] pta_s2, ptb_s2, pya_s2, pyb_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			pda_s2 <= 64'(plx_s1) * 64'(diry_s1);
			pdb_s2 <= 64'(dirx_s1) * 64'(ply_s1);
			pta_s2 <= 65'(diry_s1) * 65'(dx_s1);
			ptb_s2 <= 65'(dirx_s1) * 65'(dy_s1);
			pya_s2 <= 65'(plx_s1) * 65'(dy_s1);
			pyb_s2 <= 65'(ply_s1) * 65'(dx_s1);
		end
	end

	// Stage 3: determinant and transform numerators
	logic signed [64:0] det_s3;
	logic signed [65:0] ntx_s3, nty_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			det_s3 <= 65'(pda_s2) - 65'(pdb_s2);
			ntx_s3 <= 66'(pta_s2) - 66'(ptb_s2);
			nty_s3 <= 66'(pya_s2) - 66'(pyb_s2);
		end
	end

	// Stage 4: split into sign and magnitude
	logic [DET_W-1:0] detm_s4;
	logic [NUM_W-1:0] ntxm_s4, ntym_s4;
	logic             det_neg_s4, ntx_neg_s4, nty_neg_s4, det_zero_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			detm_s4     <= det_s3[64] ? DET_W'(-det_s3) : DET_W'(det_s3);
			ntxm_s4     <= ntx_s3[65] ? NUM_W'(-ntx_s3) : NUM_W'(ntx_s3);
			ntym_s4     <= nty_s3[65] ? NUM_W'(-nty_s3) : NUM_W'(nty_s3);
			det_neg_s4  <= det_s3[64];
			ntx_neg_s4  <= ntx_s3[65];
			nty_neg_s4  <= nty_s3[65];
			det_zero_s4 <= (det_s3 == '0);
		end
	end

	// Camera-space dividers
	logic [CAM_QB-1:0] txq, tyq;
	logic              txo, tyo;

	ssp_div #(
		.NW(NUM_W + FRACTION_BITS),
		.DW(DET_W),
		.QB(CAM_QB)
	) u_div_tx (
		.clk(clk),
		.en (en),
		.num({ntxm_s4, {FRACTION_BITS{1'b0}}}),
		.den(detm_s4),
		.quo(txq),
		.ovf(txo)
	);

	ssp_div #(
		.NW(NUM_W + FRACTION_BITS),
		.DW(DET_W),
		.QB(CAM_QB)
	) u_div_ty (
		.clk(clk),
		.en (en),
		.num({ntym_s4, {FRACTION_BITS{1'b0}}}),
		.den(detm_s4),
		.quo(tyq),
		.ovf(tyo)
	);

	// Carry signs and singular flag alongside the dividers
	cam_side_t side1_q [D1];

	always_ff @(posedge clk) begin
		if (en) begin
			side1_q[0] <= '{singular: det_zero_s4,
				tx_neg: ntx_neg_s4 ^ det_neg_s4,
				ty_neg: nty_neg_s4 ^ det_neg_s4};
			for (int i = 1; i < D1; i++) begin
				side1_q[i] <= side1_q[i-1];
			end
		end
	end

	// Stage 5: signed, saturated camera-space coordinates and status
	logic signed [31:0] tx_c, ty_c;
	status_t            st_c;
	logic signed [31:0] tx_s5, ty_s5;
	status_t            st_s5;

	always_comb begin
		if (side1_q[D1-1].tx_neg) begin
			tx_c = txo ? 32'sh80000000 : -$signed({1'b0, txq});
		end else begin
			tx_c = txo ? 32'sh7FFFFFFF : $signed({1'b0, txq});
		end
		if (side1_q[D1-1].ty_neg) begin
			ty_c = tyo ? 32'sh80000000 : -$signed({1'b0, tyq});
		end else begin
			ty_c = tyo ? 32'sh7FFFFFFF : $signed({1'b0, tyq});
		end
		if (side1_q[D1-1].singular) begin
			tx_c = '0;
			ty_c = '0;
			st_c = ST_SINGULAR;
		end else if (ty_c <= 0) begin
			st_c = ST_BEHIND;
		end else begin
			st_c = ST_OK;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tx_s5 <= tx_c;
			ty_s5 <= ty_c;
			st_s5 <= st_c;
		end
	end

	// Stage 6: lateral plus depth
	logic signed [32:0] sum_s6;
	logic signed [31:0] tx_s6, ty_s6;
	status_t            st_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s6 <= 33'(ty_s5) + 33'(tx_s5);
			tx_s6  <= tx_s5;
			ty_s6  <= ty_s5;
			st_s6  <= st_s5;
		end
	end

	// Stage 7: scale by half the frame width
	logic signed [PROD_W-1:0] prod_s7;
	logic signed [31:0]       tx_s7, ty_s7;
	status_t                  st_s7;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s7 <= PROD_W'($signed({1'b0, half_w})) * PROD_W'(sum_s6);
			tx_s7   <= tx_s6;
			ty_s7   <= ty_s6;
			st_s7   <= st_s6;
		end
	end

	// Stage 8: magnitude of the screen numerator
	logic [SMAG_W-1:0]  smag_s8;
	logic               sneg_s8;
	logic signed [31:0] tx_s8, ty_s8;
	status_t            st_s8;

	always_ff @(posedge clk) begin
		if (en) begin
			smag_s8 <= prod_s7[PROD_W-1] ? SMAG_W'(-prod_s7) : SMAG_W'(prod_s7);
			sneg_s8 <= prod_s7[PROD_W-1];
			tx_s8   <= tx_s7;
			ty_s8   <= ty_s7;
			st_s8   <= st_s7;
		end
	end

	// Screen column and sprite size dividers
	logic [SCR_QB-1:0] scrq, sizeq;
	logic              scro, sizeo;

	ssp_div #(
		.NW(SMAG_W),
		.DW(TY_W),
		.QB(SCR_QB)
	) u_div_scr (
		.clk(clk),
		.en (en),
		.num(smag_s8),
		.den(ty_s8[TY_W-1:0]),
		.quo(scrq),
		.ovf(scro)
	);

	ssp_div #(
		.NW(SZN_W),
		.DW(TY_W),
		.QB(SCR_QB)
	) u_div_size (
		.clk(clk),
		.en (en),
		.num({h_eff, {FRACTION_BITS{1'b0}}}),
		.den(ty_s8[TY_W-1:0]),
		.quo(sizeq),
		.ovf(sizeo)
	);

	scr_side_t side2_q [D2];

	always_ff @(posedge clk) begin
		if (en) begin
			side2_q[0] <= '{tx: tx_s8, ty: ty_s8, status: st_s8, scr_neg: sneg_s8};
			for (int i = 1; i < D2; i++) begin
				side2_q[i] <= side2_q[i-1];
			end
		end
	end

	// Stage 9: signed screen column, saturated well outside the frame
	logic signed [SCR_W-1:0] smag_c;
	logic signed [SCR_W-1:0] screen_s9;
	logic [SCR_QB-1:0]       size_s9;
	scr_side_t               side_s9;

	assign smag_c = scro ? (SCR_W'(1) << SCR_QB) : SCR_W'(scrq);

	always_ff @(posedge clk) begin
		if (en) begin
			screen_s9 <= side2_q[D2-1].scr_neg ? -smag_c : smag_c;
			size_s9   <= sizeo ? '1 : sizeq;
			side_s9   <= side2_q[D2-1];
		end
	end

	// Stage 10: raw draw bounds
	logic [SCR_QB-1:0]       half_sz;
	logic signed [SCR_W:0]   c0f_s10, c1f_s10, r0f_s10, r1f_s10;
	logic signed [SCR_W-1:0] screen_s10;
	logic [SCR_QB-1:0]       size_s10;
	scr_side_t               side_s10;

	assign half_sz = size_s9 >> 1;

	always_ff @(posedge clk) begin
		if (en) begin
			c0f_s10    <= (SCR_W+1)'(screen_s9) - $signed((SCR_W+1)'(half_sz));
			c1f_s10    <= (SCR_W+1)'(screen_s9) + $signed((SCR_W+1)'(half_sz));
			r0f_s10    <= $signed((SCR_W+1)'(half_h)) - $signed((SCR_W+1)'(half_sz));
			r1f_s10    <= $signed((SCR_W+1)'(half_h)) + $signed((SCR_W+1)'(half_sz));
			screen_s10 <= screen_s9;
			size_s10   <= size_s9;
			side_s10   <= side_s9;
		end
	end

	// Stage 11: clip, saturate and zero the bounds of rejected sprites
	logic signed [SCR_W:0]  c1m, r1m, hlim;
	logic signed [15:0]     scol_c, c1_c;
	logic [15:0]            ext_c;
	logic [14:0]            c0_c;
	logic [11:0]            r0_c, r1_c;
	logic signed [31:0]     csx_s11, csd_s11;
	logic signed [15:0]     scol_s11, c1_s11;
	logic [15:0]            ext_s11;
	logic [14:0]            c0_s11;
	logic [11:0]            r0_s11, r1_s11;
	status_t                st_s11;

	always_comb begin
		hlim = $signed((SCR_W+1)'(h_eff)) - 1;
		c1m  = (c1f_s10 < $signed((SCR_W+1)'(w_eff))) ? c1f_s10
			: $signed((SCR_W+1)'(w_eff));
		r1m  = (r1f_s10 < hlim) ? r1f_s10 : hlim;

		if (screen_s10 > 32767)       scol_c = 16'sh7FFF;
		else if (screen_s10 < -32768) scol_c = 16'sh8000;
		else                          scol_c = 16'(screen_s10);

		ext_c = (size_s10 > SCR_QB'(65535)) ? 16'hFFFF : 16'(size_s10);

		if (c0f_s10 < 0)          c0_c = '0;
		else if (c0f_s10 > 32767) c0_c = 15'h7FFF;
		else                      c0_c = 15'(c0f_s10);

		if (c1m > 32767)       c1_c = 16'sh7FFF;
		else if (c1m < -32768) c1_c = 16'sh8000;
		else                   c1_c = 16'(c1m);

		if (r0f_s10 < 0)         r0_c = '0;
		else if (r0f_s10 > 4095) r0_c = 12'hFFF;
		else                     r0_c = 12'(r0f_s10);

		if (r1m < 0)         r1_c = '0;
		else if (r1m > 4095) r1_c = 12'hFFF;
		else                 r1_c = 12'(r1m);

		if (side_s10.status != ST_OK) begin
			scol_c = '0;
			ext_c  = '0;
			c0_c   = '0;
			c1_c   = '0;
			r0_c   = '0;
			r1_c   = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			csx_s11  <= side_s10.tx;
			csd_s11  <= side_s10.ty;
			scol_s11 <= scol_c;
			ext_s11  <= ext_c;
			c0_s11   <= c0_c;
			c1_s11   <= c1_c;
			r0_s11   <= r0_c;
			r1_s11   <= r1_c;
			st_s11   <= side_s10.status;
		end
	end

	assign cam_space_x     = csx_s11;
	assign cam_space_depth = csd_s11;
	assign screen_column   = scol_s11;
	assign sprite_extent   = ext_s11;
	assign first_column    = c0_s11;
	assign end_column      = c1_s11;
	assign first_row       = r0_s11;
	assign end_row         = r1_s11;
	assign status          = 2'(st_s11);

`ifndef SYNTHESIS
	// Input is held back only by a waiting result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled without a waiting result");

	// A singular camera gives an all-zero result
	a_singular_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_SINGULAR) |->
		(cam_space_x == 0 && cam_space_depth == 0 && sprite_extent == 0))
		else $error("singular camera result not zero");

	// A rejected sprite gives no draw bounds
	a_reject_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != ST_OK) |->
		(first_column == 0 && end_column == 0 && first_row == 0 && end_row == 0
		&& screen_column == 0))
		else $error("rejected sprite carries draw bounds");

	// An accepted sprite lies in front of the camera
	a_ok_depth: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_OK) |-> (cam_space_depth > 0))
		else $error("ok status with non-positive depth");
`endif

endmodule
